[hw/rtl/cwig_pkg.sv]
// Shared types and constants of the convolution window index generator.
`timescale 1ns / 1ps

package cwig_pkg;

    // Fixed field widths
    localparam int PIX_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int KERNEL_W    = 3;
    localparam int HALF_W      = 2;
    localparam int DIV_CNT_W   = $clog2(PIX_W);

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KERNEL_SIZE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SKIP_BORDER = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH = 9'd7;
    localparam logic [KERNEL_W-1:0]   RST_KERNEL_SIZE = 3'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_PIXEL   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BORDER  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd2;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_SETUP,
        ST_EMIT,
        ST_FLAG
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic div_step;
        logic check;
        logic setup;
        logic emit_pix;
        logic emit_flag;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_last;
        logic flagged;
        logic slot_free;
        logic last_pix;
    } stat_t;

endpackage

[hw/rtl/cwig_cfg_regs.sv]
// Configuration registers with clamping of width and kernel to their usable ranges.
`timescale 1ns / 1ps

module cwig_cfg_regs #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_KERNEL = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cwig_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cwig_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
    output logic [cwig_pkg::HALF_W-1:0]      eff_half,
    output logic                             skip_border
);
    import cwig_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] width_next;
    logic [KERNEL_W-1:0]   kernel_reg;
    logic [KERNEL_W-1:0]   kernel_next;
    logic                  skip_reg;
    logic                  skip_next;
    logic [KERNEL_W-1:0]   kernel_clamped;

    // Decode register writes
    always_comb
    begin
        width_next  = width_reg;
        kernel_next = kernel_reg;
        skip_next   = skip_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH: width_next  = cfg_data;
                CFG_KERNEL_SIZE: kernel_next = cfg_data[KERNEL_W-1:0];
                CFG_SKIP_BORDER: skip_next   = cfg_data[0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_IMAGE_WIDTH;
            kernel_reg <= RST_KERNEL_SIZE;
            skip_reg   <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            kernel_reg <= kernel_next;
            skip_reg   <= skip_next;
        end
    end

    // Clamp width: zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        if (width_reg == '0)
            eff_width = WW'(1);
        else if (width_reg > CFG_DATA_W'(MAX_WIDTH))
            eff_width = WW'(MAX_WIDTH);
        else
            eff_width = WW'(width_reg);
    end

    // Clamp kernel and halve it
    assign kernel_clamped = (kernel_reg > KERNEL_W'(MAX_KERNEL)) ? KERNEL_W'(MAX_KERNEL)
                                                                 : kernel_reg;
    assign eff_half    = HALF_W'(kernel_clamped >> 1);
    assign skip_border = skip_reg;

endmodule

[hw/rtl/cwig_ctrl.sv]
// Controller state machine: sequences divide, bound check, setup and result emission.
`timescale 1ns / 1ps

module cwig_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  cwig_pkg::stat_t stat,
    output cwig_pkg::cmd_t  cmd
);
    import cwig_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_last)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = stat.flagged ? ST_FLAG : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.slot_free && stat.last_pix)
                    state_next = ST_IDLE;
            end
            ST_FLAG:
            begin
                if (stat.slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Commands to the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall  = 1'b0;
                cmd.start = in_valid;
            end
            ST_DIVIDE: cmd.div_step  = 1'b1;
            ST_CHECK:  cmd.check     = 1'b1;
            ST_SETUP:  cmd.setup     = 1'b1;
            ST_EMIT:   cmd.emit_pix  = stat.slot_free;
            ST_FLAG:   cmd.emit_flag = stat.slot_free;
            default:   ;
        endcase
    end

endmodule

[hw/rtl/cwig_datapath.sv]
// Datapath: restoring divider, window bounds, row and column walk, output register.
`timescale 1ns / 1ps

module cwig_datapath #(
    parameter int MAX_WIDTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cwig_pkg::cmd_t                 cmd,
    output cwig_pkg::stat_t                stat,
    input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
    input  logic [cwig_pkg::HALF_W-1:0]    eff_half,
    input  logic                           skip_border,
    input  logic [cwig_pkg::PIX_W-1:0]     pivot_index,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cwig_pkg::PIX_W-1:0]     pixel_index,
    output logic [cwig_pkg::STATUS_W-1:0]  status,
    output logic                           is_last
);
    import cwig_pkg::*;

    localparam int RW = $clog2(MAX_WIDTH);
    localparam int TW = RW + 1;
    localparam int SW = RW + 2;

    // Divider
    logic [PIX_W-1:0]     dividend_reg;
    logic [RW-1:0]        rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [TW-1:0]        trial;
    logic                 trial_ge;

    // Window bounds and flags
    logic [RW-1:0] top_reg;
    logic [RW-1:0] bottom_reg;
    logic [RW-1:0] left_reg;
    logic [RW-1:0] right_reg;
    logic          outside_reg;
    logic          border_reg;

    // Window walk
    logic [RW-1:0]    r_reg;
    logic [RW-1:0]    c_reg;
    logic [PIX_W-1:0] row_base_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [PIX_W-1:0]    pix_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    // Bound computation
    logic [RW-1:0] row;
    logic [RW-1:0] col;
    logic [SW-1:0] half_x;
    logic [SW-1:0] wmax;
    logic [SW-1:0] row_hi;
    logic [SW-1:0] col_hi;
    logic          outside;
    logic          last_pix;

    // One restoring division step
    assign trial    = {rem_reg, dividend_reg[PIX_W-1]};
    assign trial_ge = trial >= TW'(eff_width);

    // Quotient at least the width means the pivot lies beyond the image
    assign outside = dividend_reg >= PIX_W'(eff_width);
    assign row     = dividend_reg[RW-1:0];
    assign col     = rem_reg;
    assign half_x  = SW'(eff_half);
    assign wmax    = SW'(eff_width) - SW'(1);
    assign row_hi  = SW'(row) + half_x;
    assign col_hi  = SW'(col) + half_x;

    assign last_pix = (r_reg == bottom_reg) && (c_reg == right_reg);

    // Divide step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.start)
            cnt_reg <= '0;
        else if (cmd.div_step)
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
    end

    // Shift the quotient in, keep the remainder below the width
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dividend_reg <= pivot_index;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[PIX_W-2:0], trial_ge};
            rem_reg      <= trial_ge ? RW'(trial - TW'(eff_width)) : RW'(trial);
        end
    end

    // Clip the window to the image and note border pivots
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            outside_reg <= outside;
            border_reg  <= (SW'(row) < half_x) || (SW'(col) < half_x)
                           || (row_hi > wmax) || (col_hi > wmax);
            top_reg     <= (SW'(row) >= half_x) ? RW'(SW'(row) - half_x) : '0;
            left_reg    <= (SW'(col) >= half_x) ? RW'(SW'(col) - half_x) : '0;
            bottom_reg  <= (row_hi > wmax) ? RW'(wmax) : RW'(row_hi);
            right_reg   <= (col_hi > wmax) ? RW'(wmax) : RW'(col_hi);
        end
    end

    // Load the first row and walk the window row by row
    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            r_reg        <= top_reg;
            c_reg        <= left_reg;
            row_base_reg <= PIX_W'(PIX_W'(top_reg) * PIX_W'(eff_width));
        end
        else if (cmd.emit_pix)
        begin
            if (c_reg == right_reg)
            begin
                c_reg        <= left_reg;
                r_reg        <= r_reg + RW'(1);
                row_base_reg <= row_base_reg + PIX_W'(eff_width);
            end
            else
            begin
                c_reg <= c_reg + RW'(1);
            end
        end
    end

    // Hold a result until it is taken
    always_comb
    begin
        if (cmd.emit_pix || cmd.emit_flag)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pix)
        begin
            pix_reg    <= row_base_reg + PIX_W'(c_reg);
            status_reg <= STATUS_PIXEL;
            last_reg   <= last_pix;
        end
        else if (cmd.emit_flag)
        begin
            pix_reg    <= '0;
            status_reg <= outside_reg ? STATUS_OUTSIDE : STATUS_BORDER;
            last_reg   <= 1'b1;
        end
    end

    // Status to the controller
    assign stat.div_last  = cmd.div_step && (cnt_reg == DIV_CNT_W'(PIX_W - 1));
    assign stat.flagged   = outside_reg || (skip_border && border_reg);
    assign stat.slot_free = !out_valid_reg || !out_stall;
    assign stat.last_pix  = last_pix;

    assign out_valid   = out_valid_reg;
    assign pixel_index = pix_reg;
    assign status      = status_reg;
    assign is_last     = last_reg;

endmodule

[hw/rtl/conv_window_index_generator_top.sv]
// Top level of the convolution window index generator.
`timescale 1ns / 1ps

// Takes one pivot pixel index of a square row-major image, splits it into row
// and column with a 16-step restoring divider (one quotient bit per cycle), clips
// a window of kernel_size / 2 pixels to each side to the image and returns the
// flat index of every window pixel, row by row, with is_last on the final one.
// A pivot beyond the image returns one result with status 2; with skip_border
// set, a pivot within half a kernel of an edge returns one result with status 1.
// Timing: the pivot request is taken in the idle state, then the divide, bound
// check and setup (row base multiply) states follow in that order; the first
// result is then loaded and the rest at one per cycle while the output is not
// stalled, for a window of at most 49 pixels. The next pivot is taken in the
// cycle after the last result is loaded into the output register; that result
// may still be waiting to be taken. Configuration writes take effect in the
// cycle after the write.
module conv_window_index_generator_top #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_KERNEL = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cwig_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cwig_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [cwig_pkg::PIX_W-1:0]       pivot_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [cwig_pkg::PIX_W-1:0]       pixel_index,
    output logic [cwig_pkg::STATUS_W-1:0]    status,
    output logic                             is_last
);
    import cwig_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [WW-1:0]     eff_width;
    logic [HALF_W-1:0] eff_half;
    logic              skip_border;
    cmd_t              cmd;
    stat_t             stat;

    cwig_cfg_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .eff_width   (eff_width),
        .eff_half    (eff_half),
        .skip_border (skip_border)
    );

    cwig_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    cwig_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .eff_width   (eff_width),
        .eff_half    (eff_half),
        .skip_border (skip_border),
        .pivot_index (pivot_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_index (pixel_index),
        .status      (status),
        .is_last     (is_last)
    );

endmodule
